// File: design/assert_macros.svh
// Assertion macros shared by the line junction classifier modules.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LJ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lj assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LJ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lj assertion failed");

`endif

// File: design/lj_pkg.sv
// Shared types and constants for the line junction classifier.
// No dependencies; every other design file but assert_macros.svh imports this package.
package lj_pkg;

   localparam int SENSOR_W   = 10;
   localparam int COUNT_W    = 16;
   localparam int DIST_W     = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_DARK_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JUNCTION_DISTANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_DISTANCE     = 2'd2;

   localparam logic [SENSOR_W-1:0] DARK_THRESHOLD_RST    = 10'd400;
   localparam logic [DIST_W-1:0]   JUNCTION_DISTANCE_RST = 15'd80;
   localparam logic [DIST_W-1:0]   LOST_DISTANCE_RST     = 15'd0;

   typedef enum logic [1:0] {
      MODE_FOLLOW   = 2'd0,
      MODE_JUNCTION = 2'd1,
      MODE_LOST     = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      EV_CROSSROAD  = 3'd0,
      EV_T_HEAD_ON  = 3'd1,
      EV_T_LEFT     = 3'd2,
      EV_T_RIGHT    = 3'd3,
      EV_TURN_LEFT  = 3'd4,
      EV_TURN_RIGHT = 3'd5,
      EV_LINE_ENDED = 3'd6
   } event_code_type;

   typedef struct packed {
      logic [SENSOR_W-1:0]        sensor_left_outer;
      logic [SENSOR_W-1:0]        sensor_center_left;
      logic [SENSOR_W-1:0]        sensor_center;
      logic [SENSOR_W-1:0]        sensor_center_right;
      logic [SENSOR_W-1:0]        sensor_right_outer;
      logic signed [COUNT_W-1:0]  left_wheel_count;
      logic signed [COUNT_W-1:0]  right_wheel_count;
   } sample_type;

   typedef struct packed {
      logic           event_valid;
      event_code_type event_code;
      mode_type       current_mode;
   } result_type;

   typedef struct packed {
      logic [SENSOR_W-1:0] dark_threshold;
      logic [DIST_W-1:0]   junction_distance;
      logic [DIST_W-1:0]   lost_distance;
   } cfg_type;

endpackage

// File: design/lj_req_if.sv
// Input channel: one sensor sample per beat.
// Depends on lj_pkg for field widths.
interface lj_req_if;
   import lj_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [SENSOR_W-1:0]        sensor_left_outer;
   logic [SENSOR_W-1:0]        sensor_center_left;
   logic [SENSOR_W-1:0]        sensor_center;
   logic [SENSOR_W-1:0]        sensor_center_right;
   logic [SENSOR_W-1:0]        sensor_right_outer;
   logic signed [COUNT_W-1:0]  left_wheel_count;
   logic signed [COUNT_W-1:0]  right_wheel_count;

   modport source (
      output valid, sensor_left_outer, sensor_center_left, sensor_center,
             sensor_center_right, sensor_right_outer, left_wheel_count,
             right_wheel_count,
      input  ready
   );

   modport sink (
      input  valid, sensor_left_outer, sensor_center_left, sensor_center,
             sensor_center_right, sensor_right_outer, left_wheel_count,
             right_wheel_count,
      output ready
   );
endinterface

// File: design/lj_rsp_if.sv
// Result channel: one classification result per beat.
// Depends on lj_pkg for field widths.
interface lj_rsp_if;
   import lj_pkg::*;

   logic       valid;
   logic       ready;
   logic       event_valid;
   logic [2:0] event_code;
   logic [1:0] current_mode;

   modport source (
      output valid, event_valid, event_code, current_mode,
      input  ready
   );

   modport sink (
      input  valid, event_valid, event_code, current_mode,
      output ready
   );
endinterface

// File: design/lj_csr_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on lj_pkg for field widths.
interface lj_csr_if;
   import lj_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// File: design/lj_csr.sv
// Configuration registers: threshold and the two distance limits.
// Depends on lj_pkg and lj_csr_if.
module lj_csr (
   input  logic           clock,
   input  logic           reset,
   lj_csr_if.sink         csr_ch,
   output lj_pkg::cfg_type cfg_o
);
   import lj_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_ch.ready = 1'b1;
   assign write        = csr_ch.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_ch.index)
            CSR_DARK_THRESHOLD:    cfg_in.dark_threshold    = csr_ch.data[SENSOR_W-1:0];
            CSR_JUNCTION_DISTANCE: cfg_in.junction_distance = csr_ch.data[DIST_W-1:0];
            CSR_LOST_DISTANCE:     cfg_in.lost_distance     = csr_ch.data[DIST_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_threshold    <= DARK_THRESHOLD_RST;
         cfg_ff.junction_distance <= JUNCTION_DISTANCE_RST;
         cfg_ff.lost_distance     <= LOST_DISTANCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;
endmodule

// File: design/lj_core.sv
// Mode machine and classification logic for one registered sample.
// Depends on lj_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lj_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance_i,
   input  lj_pkg::sample_type  sample_i,
   input  lj_pkg::cfg_type     cfg_i,
   output lj_pkg::result_type  result_o
);
   import lj_pkg::*;

   mode_type            mode_ff, mode_in;
   logic                left_seen_ff, left_seen_in;
   logic                right_seen_ff, right_seen_in;
   logic [COUNT_W-1:0]  left_base_ff, left_base_in;
   logic [COUNT_W-1:0]  right_base_ff, right_base_in;

   logic [SENSOR_W-1:0] mid_a, mid;
   logic                lo, ro, md;
   logic [COUNT_W-1:0]  left_travel, right_travel, travel_max;
   logic                junction_reached, lost_reached;
   logic                ev_valid;
   event_code_type      ev_code;

   // Magnitude of the wrapped 16-bit difference; 0x8000 reads as 32768.
   function automatic logic [COUNT_W-1:0] wheel_travel(
      input logic [COUNT_W-1:0] cnt,
      input logic [COUNT_W-1:0] base
   );
      logic [COUNT_W-1:0] d;
      d = cnt - base;
      wheel_travel = d[COUNT_W-1] ? (~d + 1'b1) : d;
   endfunction

   always_comb begin
      mid_a = (sample_i.sensor_center > sample_i.sensor_center_left) ?
              sample_i.sensor_center : sample_i.sensor_center_left;
      mid   = (sample_i.sensor_center_right > mid_a) ? sample_i.sensor_center_right : mid_a;
      lo    = sample_i.sensor_left_outer > cfg_i.dark_threshold;
      ro    = sample_i.sensor_right_outer > cfg_i.dark_threshold;
      md    = mid > cfg_i.dark_threshold;

      left_travel  = wheel_travel(sample_i.left_wheel_count, left_base_ff);
      right_travel = wheel_travel(sample_i.right_wheel_count, right_base_ff);
      travel_max   = (left_travel > right_travel) ? left_travel : right_travel;
      junction_reached = travel_max >= {1'b0, cfg_i.junction_distance};
      lost_reached     = travel_max >= {1'b0, cfg_i.lost_distance};
   end

   always_comb begin
      mode_in       = mode_ff;
      left_seen_in  = left_seen_ff;
      right_seen_in = right_seen_ff;
      left_base_in  = left_base_ff;
      right_base_in = right_base_ff;
      ev_valid      = 1'b0;
      ev_code       = EV_CROSSROAD;

      case (mode_ff)
         MODE_JUNCTION: begin
            if (junction_reached) begin
               mode_in = MODE_FOLLOW;
               if (left_seen_ff || right_seen_ff) begin
                  ev_valid = 1'b1;
                  if (left_seen_ff && right_seen_ff) begin
                     ev_code = md ? EV_CROSSROAD : EV_T_HEAD_ON;
                  end else if (left_seen_ff) begin
                     ev_code = md ? EV_T_LEFT : EV_TURN_LEFT;
                  end else begin
                     ev_code = md ? EV_T_RIGHT : EV_TURN_RIGHT;
                  end
               end
            end else begin
               left_seen_in  = left_seen_ff | lo;
               right_seen_in = right_seen_ff | ro;
            end
         end
         MODE_LOST: begin
            if (md || lo || ro) begin
               mode_in = MODE_FOLLOW;
            end else if (lost_reached) begin
               mode_in  = MODE_FOLLOW;
               ev_valid = 1'b1;
               ev_code  = EV_LINE_ENDED;
            end
         end
         default: begin
            // Following, and the unused code treated the same way.
            mode_in = MODE_FOLLOW;
            if (lo || ro) begin
               mode_in       = MODE_JUNCTION;
               left_seen_in  = lo;
               right_seen_in = ro;
               left_base_in  = sample_i.left_wheel_count;
               right_base_in = sample_i.right_wheel_count;
            end else if (!md) begin
               mode_in       = MODE_LOST;
               left_base_in  = sample_i.left_wheel_count;
               right_base_in = sample_i.right_wheel_count;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_FOLLOW;
         left_seen_ff  <= 1'b0;
         right_seen_ff <= 1'b0;
         left_base_ff  <= '0;
         right_base_ff <= '0;
      end else if (advance_i) begin
         mode_ff       <= mode_in;
         left_seen_ff  <= left_seen_in;
         right_seen_ff <= right_seen_in;
         left_base_ff  <= left_base_in;
         right_base_ff <= right_base_in;
      end
   end

   assign result_o.event_valid  = ev_valid;
   assign result_o.event_code   = ev_code;
   assign result_o.current_mode = mode_in;

   `LJ_ASSERT_NEXT(a_event_returns_follow, clock, reset, advance_i && ev_valid, mode_ff == MODE_FOLLOW)
   `LJ_ASSERT_IMP(a_junction_has_side, clock, reset, mode_ff == MODE_JUNCTION, left_seen_ff || right_seen_ff)
   `LJ_ASSERT_NEXT(a_state_holds_idle, clock, reset, !advance_i, $stable(mode_ff) && $stable(left_base_ff))
endmodule

// File: design/line_junction_classifier_top.sv
// Top level of the line junction classifier: sample register, core, result register.
// Depends on lj_pkg, the three channel interfaces, lj_csr, lj_core, assert_macros.svh.
//
//   channel   direction  beat
//   req_ch    in         five sensor readings, two wheel counts
//   rsp_ch    out        event_valid, event_code, current_mode
//   csr_ch    in         register index, write data (always ready)
//
// One sample per cycle sustained while rsp takes each result without stalling.
// The sample register feeds the mode logic, whose result lands in the result register.
// Reset is synchronous, active high; it restores register defaults and following mode.
// A stalled rsp holds the result; the sample register still takes a beat while empty
// or while its sample moves on in the same cycle.
`include "assert_macros.svh"

module line_junction_classifier_top (
   input logic     clock,
   input logic     reset,
   lj_req_if.sink  req_ch,
   lj_rsp_if.source rsp_ch,
   lj_csr_if.sink  csr_ch
);
   import lj_pkg::*;

   logic       in_valid_ff;
   sample_type sample_ff;
   logic       out_valid_ff;
   result_type result_ff;
   result_type result_in;
   cfg_type    cfg;
   logic       advance;
   logic       req_take;
   logic       rsp_take;

   assign rsp_take     = out_valid_ff && rsp_ch.ready;
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   lj_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg_o  (cfg)
   );

   lj_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance_i (advance),
      .sample_i  (sample_ff),
      .cfg_i     (cfg),
      .result_o  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff.sensor_left_outer   <= req_ch.sensor_left_outer;
         sample_ff.sensor_center_left  <= req_ch.sensor_center_left;
         sample_ff.sensor_center       <= req_ch.sensor_center;
         sample_ff.sensor_center_right <= req_ch.sensor_center_right;
         sample_ff.sensor_right_outer  <= req_ch.sensor_right_outer;
         sample_ff.left_wheel_count    <= req_ch.left_wheel_count;
         sample_ff.right_wheel_count   <= req_ch.right_wheel_count;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.event_valid  = result_ff.event_valid;
   assign rsp_ch.event_code   = result_ff.event_code;
   assign rsp_ch.current_mode = result_ff.current_mode;

   `LJ_ASSERT_NEXT(a_sample_held, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(sample_ff))
   `LJ_ASSERT_NEXT(a_result_drains, clock, reset, rsp_take && !advance, !out_valid_ff)
endmodule

// File: tb/tb_line_junction_classifier_top.sv
`timescale 1ns / 100ps
// Self-checking bench for line_junction_classifier_top: directed and random sensor beats,
// each predicted by a scoreboard class and checked against the result channel.
// Depends on lj_pkg and the lj_req_if, lj_rsp_if and lj_csr_if interfaces.
module tb_line_junction_classifier_top;
   import lj_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 90;
   localparam int TAIL_CYCLES    = 8;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 75;

   class junction_scoreboard;
      logic [SENSOR_W-1:0] dark_threshold;
      logic [DIST_W-1:0]   junction_limit;
      logic [DIST_W-1:0]   lost_limit;
      mode_type            mode;
      logic                left_seen;
      logic                right_seen;
      logic [COUNT_W-1:0]  left_base;
      logic [COUNT_W-1:0]  right_base;
      result_type          expected_q[$];
      int                  failures;

      function new();
         dark_threshold = DARK_THRESHOLD_RST;
         junction_limit = JUNCTION_DISTANCE_RST;
         lost_limit     = LOST_DISTANCE_RST;
         mode           = MODE_FOLLOW;
         left_seen      = 1'b0;
         right_seen     = 1'b0;
         left_base      = '0;
         right_base     = '0;
         failures       = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_DARK_THRESHOLD:    dark_threshold = value[SENSOR_W-1:0];
            CSR_JUNCTION_DISTANCE: junction_limit = value[DIST_W-1:0];
            CSR_LOST_DISTANCE:     lost_limit = value[DIST_W-1:0];
            default: ;
         endcase
      endfunction

      // Magnitude of the wrapped 16-bit difference, 0..32768.
      function logic [16:0] wheel_span(logic [COUNT_W-1:0] count, logic [COUNT_W-1:0] base);
         logic [COUNT_W-1:0] d;
         d = count - base;
         return d[COUNT_W-1] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
      endfunction

      function logic [16:0] travel(sample_type s);
         logic [16:0] a;
         logic [16:0] b;
         a = wheel_span(s.left_wheel_count, left_base);
         b = wheel_span(s.right_wheel_count, right_base);
         return (a > b) ? a : b;
      endfunction

      function void note_sample(sample_type s);
         logic [SENSOR_W-1:0] mid;
         logic                lo;
         logic                ro;
         logic                md;
         result_type          r;
         mid = s.sensor_center_left;
         if (s.sensor_center > mid) mid = s.sensor_center;
         if (s.sensor_center_right > mid) mid = s.sensor_center_right;
         lo = s.sensor_left_outer > dark_threshold;
         ro = s.sensor_right_outer > dark_threshold;
         md = mid > dark_threshold;
         r.event_valid = 1'b0;
         r.event_code = EV_CROSSROAD;
         case (mode)
            MODE_JUNCTION: begin
               if (travel(s) >= {2'b00, junction_limit}) begin
                  mode = MODE_FOLLOW;
                  if (left_seen || right_seen) begin
                     r.event_valid = 1'b1;
                     if (left_seen && right_seen)
                        r.event_code = md ? EV_CROSSROAD : EV_T_HEAD_ON;
                     else if (left_seen)
                        r.event_code = md ? EV_T_LEFT : EV_TURN_LEFT;
                     else
                        r.event_code = md ? EV_T_RIGHT : EV_TURN_RIGHT;
                  end
               end else begin
                  left_seen = left_seen | lo;
                  right_seen = right_seen | ro;
               end
            end
            MODE_LOST: begin
               if (md || lo || ro) begin
                  mode = MODE_FOLLOW;
               end else if (travel(s) >= {2'b00, lost_limit}) begin
                  mode = MODE_FOLLOW;
                  r.event_valid = 1'b1;
                  r.event_code = EV_LINE_ENDED;
               end
            end
            default: begin
               mode = MODE_FOLLOW;
               if (lo || ro) begin
                  mode = MODE_JUNCTION;
                  left_seen = lo;
                  right_seen = ro;
                  left_base = s.left_wheel_count;
                  right_base = s.right_wheel_count;
               end else if (!md) begin
                  mode = MODE_LOST;
                  left_base = s.left_wheel_count;
                  right_base = s.right_wheel_count;
               end
            end
         endcase
         r.current_mode = mode;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic got_valid, logic [2:0] got_code, logic [1:0] got_mode);
         result_type exp;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing outstanding: event_valid %0d event_code %0d current_mode %0d",
                   got_valid, got_code, got_mode);
            failures++;
            return;
         end
         exp = expected_q.pop_front();
         if (got_valid !== exp.event_valid) begin
            $error("event_valid: expected %0d, got %0d", exp.event_valid, got_valid);
            failures++;
         end
         if (got_code !== exp.event_code) begin
            $error("event_code: expected %0d, got %0d", exp.event_code, got_code);
            failures++;
         end
         if (got_mode !== exp.current_mode) begin
            $error("current_mode: expected %0d, got %0d", exp.current_mode, got_mode);
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   lj_req_if req_ch();
   lj_rsp_if rsp_ch();
   lj_csr_if csr_ch();

   line_junction_classifier_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   junction_scoreboard  sb;
   logic [SENSOR_W-1:0] cfg_threshold;
   logic [DIST_W-1:0]   cfg_junction;
   logic [DIST_W-1:0]   cfg_lost;
   logic [COUNT_W-1:0]  left_pos;
   logic [COUNT_W-1:0]  right_pos;
   bit                  tx_calm;
   bit                  rx_calm;
   bit                  hold_request;
   int                  sent_count;
   int                  idle_cycles;

   always #5 clock = ~clock;

   always @(posedge clock) begin : sample_monitor
      sample_type s;
      if (!reset && req_ch.valid && req_ch.ready) begin
         s.sensor_left_outer   = req_ch.sensor_left_outer;
         s.sensor_center_left  = req_ch.sensor_center_left;
         s.sensor_center       = req_ch.sensor_center;
         s.sensor_center_right = req_ch.sensor_center_right;
         s.sensor_right_outer  = req_ch.sensor_right_outer;
         s.left_wheel_count    = req_ch.left_wheel_count;
         s.right_wheel_count   = req_ch.right_wheel_count;
         sb.note_sample(s);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.event_valid, rsp_ch.event_code, rsp_ch.current_mode);
   end

   always @(posedge clock) begin
      if (!reset && csr_ch.valid && csr_ch.ready)
         sb.set_register(csr_ch.index, csr_ch.data);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function int receiver_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   function int sender_gap();
      int r;
      if (tx_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side: random stalls, plus one long hold-off when asked.
   initial begin : receiver
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 3) == 0) stall = receiver_stall();
         end
         @(posedge clock);
      end
   end

   // Hold valid high after the beat unless a sender gap drops it; the next call or settle() decides what follows.
   task send_sample(input sample_type s);
      int g;
      req_ch.sensor_left_outer   <= s.sensor_left_outer;
      req_ch.sensor_center_left  <= s.sensor_center_left;
      req_ch.sensor_center       <= s.sensor_center;
      req_ch.sensor_center_right <= s.sensor_center_right;
      req_ch.sensor_right_outer  <= s.sensor_right_outer;
      req_ch.left_wheel_count    <= s.left_wheel_count;
      req_ch.right_wheel_count   <= s.right_wheel_count;
      req_ch.valid               <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
      g = sender_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task write_config(input logic [SENSOR_W-1:0] threshold, input logic [DIST_W-1:0] junction,
                     input logic [DIST_W-1:0] lost);
      csr_beat(CSR_DARK_THRESHOLD, {5'd0, threshold});
      csr_beat(CSR_JUNCTION_DISTANCE, junction);
      csr_beat(CSR_LOST_DISTANCE, lost);
      csr_ch.valid <= 1'b0;
      cfg_threshold = threshold;
      cfg_junction = junction;
      cfg_lost = lost;
   endtask

   // Drop valid, let the last beat reach the scoreboard, then wait out every result.
   task settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function sample_type mk(logic [9:0] a, logic [9:0] b, logic [9:0] c, logic [9:0] d,
                           logic [9:0] e, logic [15:0] lc, logic [15:0] rc);
      sample_type s;
      s.sensor_left_outer   = a;
      s.sensor_center_left  = b;
      s.sensor_center       = c;
      s.sensor_center_right = d;
      s.sensor_right_outer  = e;
      s.left_wheel_count    = lc;
      s.right_wheel_count   = rc;
      return s;
   endfunction

   // A reading on or off the line at the current threshold; nothing is on at 1000.
   function logic [SENSOR_W-1:0] reading(bit on);
      if (on && cfg_threshold < 10'd1000) begin
         if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 10'd1000 : cfg_threshold + 10'd1;
         return 10'($urandom_range(1000, int'(cfg_threshold) + 1));
      end
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? cfg_threshold : 10'd0;
      return 10'($urandom_range(int'(cfg_threshold), 0));
   endfunction

   function sample_type line_sample(bit left_on, bit mid_on, bit right_on,
                                    logic [15:0] lc, logic [15:0] rc);
      sample_type s;
      int pick;
      pick = mid_on ? int'($urandom_range(0, 2)) : -1;
      s.sensor_left_outer   = reading(left_on);
      s.sensor_center_left  = reading(pick == 0 || (pick >= 0 && $urandom_range(0, 3) == 0));
      s.sensor_center       = reading(pick == 1 || (pick >= 0 && $urandom_range(0, 3) == 0));
      s.sensor_center_right = reading(pick == 2 || (pick >= 0 && $urandom_range(0, 3) == 0));
      s.sensor_right_outer  = reading(right_on);
      s.left_wheel_count    = lc;
      s.right_wheel_count   = rc;
      return s;
   endfunction

   // Put the leading wheel at the given distance from its baseline, jitter the other.
   function void place_wheels(logic [15:0] base_l, logic [15:0] base_r, bit left_leads,
                              int span);
      int jitter;
      jitter = int'($urandom_range(0, 6)) - 3;
      left_pos = 16'(int'(base_l) + (left_leads ? span : jitter));
      right_pos = 16'(int'(base_r) + (left_leads ? jitter : span));
   endfunction

   function void creep();
      left_pos = left_pos + 16'($urandom_range(0, 20));
      right_pos = right_pos + 16'($urandom_range(0, 20));
   endfunction

   function int step_offset(int limit, int k, int n);
      if (k == n) return limit + int'($urandom_range(0, 2));
      if (limit > 0 && $urandom_range(0, 4) == 0) return limit - 1;
      return (limit * k) / n;
   endfunction

   task junction_run();
      int          n;
      int          k;
      int          dir;
      bit          lo;
      bit          ro;
      bit          left_leads;
      logic [15:0] base_l;
      logic [15:0] base_r;
      case ($urandom_range(0, 2))
         0: begin lo = 1'b1; ro = 1'b0; end
         1: begin lo = 1'b0; ro = 1'b1; end
         default: begin lo = 1'b1; ro = 1'b1; end
      endcase
      creep();
      base_l = left_pos;
      base_r = right_pos;
      send_sample(line_sample(lo, $urandom_range(0, 1), ro, base_l, base_r));
      n = $urandom_range(1, 5);
      dir = ($urandom_range(0, 3) == 0) ? -1 : 1;
      left_leads = $urandom_range(0, 1);
      for (k = 1; k <= n; k++) begin
         place_wheels(base_l, base_r, left_leads, dir * step_offset(int'(cfg_junction), k, n));
         send_sample(line_sample(k < n && $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                                 k < n && $urandom_range(0, 3) == 0, left_pos, right_pos));
      end
   endtask

   task lost_run();
      int          n;
      int          k;
      int          dir;
      bit          left_leads;
      bit          found;
      logic [15:0] base_l;
      logic [15:0] base_r;
      creep();
      base_l = left_pos;
      base_r = right_pos;
      send_sample(line_sample(1'b0, 1'b0, 1'b0, base_l, base_r));
      n = $urandom_range(1, 5);
      dir = ($urandom_range(0, 3) == 0) ? -1 : 1;
      left_leads = $urandom_range(0, 1);
      found = 1'b0;
      for (k = 1; k <= n && !found; k++) begin
         place_wheels(base_l, base_r, left_leads, dir * step_offset(int'(cfg_lost), k, n));
         if (k < n && $urandom_range(0, 5) == 0) begin
            // line found again before the limit
            case ($urandom_range(0, 2))
               0: send_sample(line_sample(1'b0, 1'b1, 1'b0, left_pos, right_pos));
               1: send_sample(line_sample(1'b1, 1'b0, 1'b0, left_pos, right_pos));
               default: send_sample(line_sample(1'b0, 1'b0, 1'b1, left_pos, right_pos));
            endcase
            found = 1'b1;
         end else begin
            send_sample(line_sample(1'b0, 1'b0, 1'b0, left_pos, right_pos));
         end
      end
   endtask

   task random_items(input int count);
      int target;
      int r;
      int m;
      target = sent_count + count;
      while (sent_count < target) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            junction_run();
         end else if (r < 60) begin
            lost_run();
         end else if (r < 82) begin
            m = $urandom_range(1, 6);
            repeat (m) begin
               creep();
               send_sample(line_sample(1'b0, 1'b1, 1'b0, left_pos, right_pos));
            end
         end else begin
            m = $urandom_range(1, 3);
            repeat (m) begin
               left_pos = 16'($urandom);
               right_pos = 16'($urandom);
               send_sample(mk(10'($urandom_range(0, 1000)), 10'($urandom_range(0, 1000)),
                              10'($urandom_range(0, 1000)), 10'($urandom_range(0, 1000)),
                              10'($urandom_range(0, 1000)), left_pos, right_pos));
            end
         end
      end
   endtask

   function logic [DIST_W-1:0] pick_distance();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r < 7) return 15'($urandom_range(1, 150));
      return 15'($urandom_range(151, 32767));
   endfunction

   // Runs at reset settings: threshold 400, junction 80, lost 0.
   task directed_items();
      send_sample(mk(0, 0, 0, 0, 0, 16'h0000, 16'h0000));
      send_sample(mk(0, 0, 0, 0, 0, 16'h0000, 16'h0000));
      send_sample(mk(1000, 1000, 1000, 1000, 1000, 16'h7FFF, 16'h8000));
      send_sample(mk(0, 401, 0, 0, 0, 16'h804E, 16'h8000));
      send_sample(mk(0, 0, 401, 0, 0, 16'h804F, 16'h8000));
      send_sample(mk(401, 0, 0, 0, 1000, 16'h0000, 16'h0000));
      send_sample(mk(0, 0, 0, 0, 0, 16'h0000, 16'hFFB0));
      send_sample(mk(1000, 0, 0, 0, 400, 16'h0064, 16'h0064));
      send_sample(mk(0, 0, 0, 1000, 0, 16'h00B4, 16'h0064));
      send_sample(mk(500, 600, 0, 0, 0, 16'hFFFF, 16'hFFFF));
      send_sample(mk(0, 0, 0, 0, 0, 16'hFFFF, 16'h004F));
      send_sample(mk(0, 700, 0, 0, 1000, 16'h8000, 16'h8000));
      send_sample(mk(0, 0, 1000, 0, 0, 16'h7FB0, 16'h8000));
      send_sample(mk(0, 0, 0, 0, 999, 16'h1234, 16'h1234));
      send_sample(mk(0, 400, 400, 400, 0, 16'h1284, 16'h1234));
      send_sample(mk(0, 0, 0, 0, 1000, 16'h0000, 16'h0000));
      send_sample(mk(1000, 0, 0, 0, 0, 16'h0000, 16'h000A));
      // full half-range travel on one wheel
      send_sample(mk(0, 0, 0, 0, 0, 16'h8000, 16'h0000));
      send_sample(mk(0, 1000, 1000, 1000, 0, 16'h7FFF, 16'h7FFF));
      send_sample(mk(0, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF));
      send_sample(mk(0, 0, 401, 0, 0, 16'h7FFF, 16'h7FFF));
      send_sample(mk(400, 400, 400, 400, 400, 16'hFFFF, 16'h0001));
      send_sample(mk(1000, 0, 0, 0, 0, 16'hFFFF, 16'h0001));
      send_sample(mk(0, 0, 0, 0, 0, 16'h5555, 16'hAAAA));
      send_sample(mk(0, 0, 0, 0, 401, 16'h5555, 16'hAAAA));
      left_pos = 16'h5555;
      right_pos = 16'hAAAA;
   endtask

   initial begin : stimulus
      int i;
      sb = new();
      reset                      <= 1'b1;
      req_ch.valid               <= 1'b0;
      req_ch.sensor_left_outer   <= '0;
      req_ch.sensor_center_left  <= '0;
      req_ch.sensor_center       <= '0;
      req_ch.sensor_center_right <= '0;
      req_ch.sensor_right_outer  <= '0;
      req_ch.left_wheel_count    <= '0;
      req_ch.right_wheel_count   <= '0;
      csr_ch.valid               <= 1'b0;
      csr_ch.index               <= CSR_DARK_THRESHOLD;
      csr_ch.data                <= '0;
      cfg_threshold = DARK_THRESHOLD_RST;
      cfg_junction = JUNCTION_DISTANCE_RST;
      cfg_lost = LOST_DISTANCE_RST;
      left_pos = '0;
      right_pos = '0;
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      hold_request = 1'b0;
      sent_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      settle();
      tx_calm = 1'b1;
      rx_calm = 1'b1;
      random_items(100);
      settle();
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      write_config(10'd0, 15'd0, 15'd0);
      random_items(80);
      settle();
      write_config(10'd1000, 15'd32767, 15'd32767);
      random_items(60);
      settle();
      // back up the result side while samples keep coming
      write_config(10'($urandom_range(50, 950)), pick_distance(), pick_distance());
      hold_request = 1'b1;
      tx_calm = 1'b1;
      random_items(40);
      tx_calm = 1'b0;
      random_items(50);
      for (i = 0; i < RANDOM_PHASES; i++) begin
         settle();
         write_config(10'($urandom_range(50, 950)), pick_distance(), pick_distance());
         rx_calm = (i == 2);
         random_items(PHASE_ITEMS);
      end
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

// File: sim.f
+incdir+design
design/lj_pkg.sv
design/lj_req_if.sv
design/lj_rsp_if.sv
design/lj_csr_if.sv
design/lj_csr.sv
design/lj_core.sv
design/line_junction_classifier_top.sv
tb/tb_line_junction_classifier_top.sv
